### rtl/core/qvr_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion vector rotation pipeline.
// Holds widths, beat types and product index names; it depends on nothing.
package qvr_pkg;

  // Field widths of the input and result beats.
  localparam int VEC_W  = 16;
  localparam int FRAC_W = 14;
  localparam int QUAT_W = FRAC_W + 2;

  // Internal widths: quaternion pair products, rotation matrix entries,
  // matrix times vector products, row sums and the rounded row value.
  localparam int QQ_W  = 2 * QUAT_W;
  localparam int M_W   = QQ_W + 2;
  localparam int P_W   = M_W + VEC_W;
  localparam int ACC_W = P_W + 2;
  localparam int SH    = 2 * FRAC_W;
  localparam int RND_W = ACC_W - SH;

  // Rounding offset of one half at the product scale.
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (SH - 1);

  // Saturation bounds at the rounded width.
  localparam logic signed [RND_W-1:0] RND_MAX =
    {{(RND_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] RND_MIN = ~RND_MAX;

  // Saturation bounds at the result width.
  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  // Places of the ten distinct quaternion pair products.
  localparam int NUM_PAIRS = 10;
  localparam int PR_WW = 0;
  localparam int PR_WX = 1;
  localparam int PR_WY = 2;
  localparam int PR_WZ = 3;
  localparam int PR_XX = 4;
  localparam int PR_XY = 5;
  localparam int PR_XZ = 6;
  localparam int PR_YY = 7;
  localparam int PR_YZ = 8;
  localparam int PR_ZZ = 9;

  // Input beat.
  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    overflow;
  } result_t;

endpackage

### rtl/core/qvr_pair_mul.sv
`timescale 1ns / 1ps
// First pipeline stage: the ten products of quaternion component pairs.
// Depends on qvr_pkg.
module qvr_pair_mul (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  qvr_pkg::item_t                           item,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [qvr_pkg::QQ_W-1:0]          pair [qvr_pkg::NUM_PAIRS],
  output logic signed [qvr_pkg::VEC_W-1:0]         vec  [3]
);

  // The stage takes a beat when it is empty or its beat moves on.
  assign in_ready = !out_valid || out_ready;

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Pair products, sign extended to full width before multiplying.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pair[qvr_pkg::PR_WW] <= qvr_pkg::QQ_W'(item.quat_w) * qvr_pkg::QQ_W'(item.quat_w);
      pair[qvr_pkg::PR_WX] <= qvr_pkg::QQ_W'(item.quat_w) * qvr_pkg::QQ_W'(item.quat_x);
      pair[qvr_pkg::PR_WY] <= qvr_pkg::QQ_W'(item.quat_w) * qvr_pkg::QQ_W'(item.quat_y);
      pair[qvr_pkg::PR_WZ] <= qvr_pkg::QQ_W'(item.quat_w) * qvr_pkg::QQ_W'(item.quat_z);
      pair[qvr_pkg::PR_XX] <= qvr_pkg::QQ_W'(item.quat_x) * qvr_pkg::QQ_W'(item.quat_x);
      pair[qvr_pkg::PR_XY] <= qvr_pkg::QQ_W'(item.quat_x) * qvr_pkg::QQ_W'(item.quat_y);
      pair[qvr_pkg::PR_XZ] <= qvr_pkg::QQ_W'(item.quat_x) * qvr_pkg::QQ_W'(item.quat_z);
      pair[qvr_pkg::PR_YY] <= qvr_pkg::QQ_W'(item.quat_y) * qvr_pkg::QQ_W'(item.quat_y);
      pair[qvr_pkg::PR_YZ] <= qvr_pkg::QQ_W'(item.quat_y) * qvr_pkg::QQ_W'(item.quat_z);
      pair[qvr_pkg::PR_ZZ] <= qvr_pkg::QQ_W'(item.quat_z) * qvr_pkg::QQ_W'(item.quat_z);
      vec[0] <= item.vec_x;
      vec[1] <= item.vec_y;
      vec[2] <= item.vec_z;
    end
  end

endmodule

### rtl/core/qvr_matrix.sv
`timescale 1ns / 1ps
// Second pipeline stage: the nine entries of the rotation matrix of q,
// exact at the squared fraction scale. Depends on qvr_pkg.
module qvr_matrix (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qvr_pkg::QQ_W-1:0]     pair [qvr_pkg::NUM_PAIRS],
  input  logic signed [qvr_pkg::VEC_W-1:0]    vec_in [3],
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qvr_pkg::M_W-1:0]      mat [3][3],
  output logic signed [qvr_pkg::VEC_W-1:0]    vec [3]
);

  logic signed [qvr_pkg::M_W-1:0] ww, wx, wy, wz, xx, xy, xz, yy, yz, zz;

  assign in_ready = !out_valid || out_ready;

  // Widen the pair products so that sums of four cannot wrap.
  always_comb begin
    ww = qvr_pkg::M_W'(pair[qvr_pkg::PR_WW]);
    wx = qvr_pkg::M_W'(pair[qvr_pkg::PR_WX]);
    wy = qvr_pkg::M_W'(pair[qvr_pkg::PR_WY]);
    wz = qvr_pkg::M_W'(pair[qvr_pkg::PR_WZ]);
    xx = qvr_pkg::M_W'(pair[qvr_pkg::PR_XX]);
    xy = qvr_pkg::M_W'(pair[qvr_pkg::PR_XY]);
    xz = qvr_pkg::M_W'(pair[qvr_pkg::PR_XZ]);
    yy = qvr_pkg::M_W'(pair[qvr_pkg::PR_YY]);
    yz = qvr_pkg::M_W'(pair[qvr_pkg::PR_YZ]);
    zz = qvr_pkg::M_W'(pair[qvr_pkg::PR_ZZ]);
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Matrix entries of q (0,v) conj(q); the off-diagonal terms are doubled.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mat[0][0] <= ww + xx - yy - zz;
      mat[0][1] <= (xy - wz) <<< 1;
      mat[0][2] <= (xz + wy) <<< 1;
      mat[1][0] <= (xy + wz) <<< 1;
      mat[1][1] <= ww - xx + yy - zz;
      mat[1][2] <= (yz - wx) <<< 1;
      mat[2][0] <= (xz - wy) <<< 1;
      mat[2][1] <= (yz + wx) <<< 1;
      mat[2][2] <= ww - xx - yy + zz;
      vec       <= vec_in;
    end
  end

endmodule

### rtl/core/qvr_mat_vec.sv
`timescale 1ns / 1ps
// Third pipeline stage: the nine products of matrix entries and vector
// components. Depends on qvr_pkg.
module qvr_mat_vec (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qvr_pkg::M_W-1:0]      mat [3][3],
  input  logic signed [qvr_pkg::VEC_W-1:0]    vec [3],
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qvr_pkg::P_W-1:0]      prod [3][3]
);

  assign in_ready = !out_valid || out_ready;

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // One multiplier per matrix entry.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= qvr_pkg::P_W'(mat[r][c]) * qvr_pkg::P_W'(vec[c]);
        end
      end
    end
  end

endmodule

### rtl/core/qvr_round_sat.sv
`timescale 1ns / 1ps
// Last two pipeline stages: row sums with rounding, then saturation into
// the result beat. Depends on qvr_pkg.
module qvr_round_sat (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qvr_pkg::P_W-1:0]      prod [3][3],
  output logic                                out_valid,
  input  logic                                out_ready,
  output qvr_pkg::result_t                    result
);

  logic                                 rnd_valid;
  logic                                 rnd_ready;
  logic signed [qvr_pkg::RND_W-1:0]     rnd [3];
  logic signed [qvr_pkg::ACC_W-1:0]     row_sum [3];
  logic signed [qvr_pkg::VEC_W-1:0]     sat [3];
  logic [2:0]                           clamp;

  assign rnd_ready = !out_valid || out_ready;
  assign in_ready  = !rnd_valid || rnd_ready;

  // Row sums plus one half, so the shift rounds to nearest, ties upward.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = qvr_pkg::ACC_W'(prod[r][0]) + qvr_pkg::ACC_W'(prod[r][1])
                 + qvr_pkg::ACC_W'(prod[r][2]) + qvr_pkg::HALF;
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        rnd_valid <= in_valid;
      end
      if (rnd_ready) begin
        out_valid <= rnd_valid;
      end
    end
  end

  // Rounding stage.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        rnd[r] <= qvr_pkg::RND_W'(row_sum[r] >>> qvr_pkg::SH);
      end
    end
  end

  // Clamp each row to the result range.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (rnd[r] > qvr_pkg::RND_MAX) begin
        sat[r]   = qvr_pkg::VEC_MAX;
        clamp[r] = 1'b1;
      end else if (rnd[r] < qvr_pkg::RND_MIN) begin
        sat[r]   = qvr_pkg::VEC_MIN;
        clamp[r] = 1'b1;
      end else begin
        sat[r]   = rnd[r][qvr_pkg::VEC_W-1:0];
        clamp[r] = 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rnd_ready && rnd_valid) begin
      result.rot_x    <= sat[0];
      result.rot_y    <= sat[1];
      result.rot_z    <= sat[2];
      result.overflow <= |clamp;
    end
  end

endmodule

### rtl/core/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Quaternion vector rotation: five register stages.
// Throughput is one beat per cycle when nothing stalls; each stage moves on
// when it is empty or the stage after it moves, so stalls lose and repeat
// nothing. Synchronous reset clears every stage valid bit; the data path
// registers are not reset.
module quaternion_vector_rotate (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  qvr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output qvr_pkg::result_t result
);

  logic                               s1_valid, s1_ready;
  logic                               s2_valid, s2_ready;
  logic                               s3_valid, s3_ready;
  logic                               in_ready;
  logic signed [qvr_pkg::QQ_W-1:0]    pair [qvr_pkg::NUM_PAIRS];
  logic signed [qvr_pkg::VEC_W-1:0]   s1_vec [3];
  logic signed [qvr_pkg::VEC_W-1:0]   s2_vec [3];
  logic signed [qvr_pkg::M_W-1:0]     mat [3][3];
  logic signed [qvr_pkg::P_W-1:0]     prod [3][3];

  assign item_stall = !in_ready;

  // Quaternion pair products.
  qvr_pair_mul u_pair (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (in_ready),
    .item      (item),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .pair      (pair),
    .vec       (s1_vec)
  );

  // Rotation matrix.
  qvr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .pair      (pair),
    .vec_in    (s1_vec),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .mat       (mat),
    .vec       (s2_vec)
  );

  // Matrix times vector products.
  qvr_mat_vec u_mat_vec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .mat       (mat),
    .vec       (s2_vec),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .prod      (prod)
  );

  // Row sums, rounding and saturation.
  qvr_round_sat u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .prod      (prod),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .result    (result)
  );

endmodule

### rtl/core/qvr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the quaternion vector rotation pipeline, bound to
// the top level. Depends on qvr_pkg.
module qvr_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input qvr_pkg::result_t result
);

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // With the output register empty, every stage can take a beat.
  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while the pipeline drains freely");

  // An overflow flag comes with at least one clamped component.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |->
      result.rot_x == qvr_pkg::VEC_MAX || result.rot_x == qvr_pkg::VEC_MIN ||
      result.rot_y == qvr_pkg::VEC_MAX || result.rot_y == qvr_pkg::VEC_MIN ||
      result.rot_z == qvr_pkg::VEC_MAX || result.rot_z == qvr_pkg::VEC_MIN)
    else $error("overflow flag without a clamped component");

  // An accepted beat is not lost: once it could have passed every stage,
  // the output holds it or a beat ahead of it that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_stall |-> ##5 result_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
